/* rtl/vc32_pkg.sv */
package vc32_pkg;

   // Request codes
   localparam logic REQ_DECODE = 1'b0;
   localparam logic REQ_ENCODE = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned GROUP_W  = 7;
   localparam int unsigned COUNT_W  = 3;
   localparam int unsigned ROOM_W   = 3;

   localparam logic [7:0]         GROUP_MASK = 8'h7F;
   localparam logic [7:0]         MORE_BIT   = 8'h80;
   localparam logic [COUNT_W-1:0] MAX_GROUPS = 3'd5;

   // Outcome of one decode byte.
   typedef struct packed {
      logic               valid;  // byte produces a result
      logic               error;  // result is a decode error
      logic [VALUE_W-1:0] value;  // completed value
   } dec_result_type;

   // One step of the encoder.
   typedef struct packed {
      logic [7:0]         out_byte;
      logic [VALUE_W-1:0] rest;   // value left after this byte
      logic               last;   // this is the final byte of the run
   } enc_step_type;

endpackage

/* rtl/vc32_decode.sv */
module vc32_decode
   import vc32_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     in_byte,
   input  logic           buffer_end,
   output dec_result_type result,
   output logic [COUNT_W-1:0] group_count
);

   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [4:0]         shift;
   logic [VALUE_W-1:0] merged;
   logic [COUNT_W-1:0] next_count;

   // Group index is at most four, so the shift never exceeds 28.
   assign shift      = 5'(cnt_ff) * 5'd7;
   assign merged     = acc_ff | (VALUE_W'(in_byte & GROUP_MASK) << shift);
   assign next_count = cnt_ff + 3'd1;

   always_comb begin
      result.valid = 1'b0;
      result.error = 1'b0;
      result.value = merged;
      acc_in       = merged;
      cnt_in       = next_count;
      if ((in_byte & MORE_BIT) == 8'h00) begin
         result.valid = 1'b1;
         acc_in       = '0;
         cnt_in       = '0;
      end else if (next_count >= MAX_GROUPS || buffer_end) begin
         result.valid = 1'b1;
         result.error = 1'b1;
         acc_in       = '0;
         cnt_in       = '0;
      end
   end

   assign group_count = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else if (step) begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* rtl/vc32_encode.sv */
module vc32_encode
   import vc32_pkg::*;
(
   input  logic [VALUE_W-1:0] value,
   input  logic [ROOM_W-1:0]  room,
   output enc_step_type       enc
);

   logic [VALUE_W-1:0] rest;

   assign rest = value >> GROUP_W;

   always_comb begin
      enc.rest     = rest;
      enc.out_byte = (value[7:0] & GROUP_MASK) | ((rest != '0) ? MORE_BIT : 8'h00);
      // Run ends when the value is used up or the room runs out.
      enc.last     = (rest == '0) || (room == 3'd1);
   end

endmodule

/* rtl/varint32_codec.sv */
// A 32-bit varint codec: seven data bits per byte, least significant group
// first, bit 7 set when more bytes follow. A decode request carries one byte;
// the codec gathers groups and returns the value once a byte has bit 7 clear,
// or an error when a fifth byte still continues or the buffer ends mid-value.
// An encode request carries a value and the free room (six and seven count as
// five) and returns one byte per cycle while the result register can take it,
// at most min(room, 5) bytes, with the final byte marked by last; negative
// values are encoded as their 32-bit pattern. Every request passes through a
// single work register in front of the result register. A decode request
// leaves the work register once its byte is handled, and a new request can
// be taken as it leaves; an encode request stays there until its last byte is
// handed on, and one with room zero leaves without a byte. While the work
// register is free, a request is taken even if an earlier result still waits.
module varint32_codec
   import vc32_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_type,
   input  logic [7:0]                req_in_byte,
   input  logic                      req_buffer_end,
   input  logic signed [VALUE_W-1:0] req_value_in,
   input  logic [ROOM_W-1:0]         req_room,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_kind,
   output logic [7:0]                rsp_out_byte,
   output logic signed [VALUE_W-1:0] rsp_decoded_value,
   output logic                      rsp_last
);

   // Work register: the request currently being processed.
   logic               w_valid_ff, w_valid_in;
   logic               w_type_ff;
   logic [7:0]         w_byte_ff;
   logic               w_end_ff;
   logic [VALUE_W-1:0] w_value_ff, w_value_in;
   logic [ROOM_W-1:0]  w_room_ff, w_room_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_kind_ff, rsp_kind_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               req_accept;
   logic               out_free;
   logic               produces;
   logic               item_done;
   logic               fire;
   logic               w_done;
   logic               load_rsp;
   logic               dec_step;
   logic [ROOM_W-1:0]  room_clamped;

   dec_result_type     dec_res;
   logic [COUNT_W-1:0] dec_count;
   enc_step_type       enc;

   vc32_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .step        (dec_step),
      .in_byte     (w_byte_ff),
      .buffer_end  (w_end_ff),
      .result      (dec_res),
      .group_count (dec_count)
   );

   vc32_encode u_encode (
      .value (w_value_ff),
      .room  (w_room_ff),
      .enc   (enc)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Does the work register produce a result this cycle, and is the request
   // finished once it does?
   always_comb begin
      if (w_type_ff == REQ_DECODE) begin
         produces  = dec_res.valid;
         item_done = 1'b1;
      end else begin
         produces  = (w_room_ff != '0);
         item_done = (w_room_ff == '0) || enc.last;
      end
   end

   // A request that produces nothing may proceed even when the output is full.
   assign fire       = w_valid_ff && (!produces || out_free);
   assign w_done     = fire && item_done;
   assign load_rsp   = fire && produces;
   assign dec_step   = fire && (w_type_ff == REQ_DECODE);
   assign req_ready  = !w_valid_ff || w_done;
   assign req_accept = req_valid && req_ready;

   assign room_clamped = (req_room > ROOM_W'(MAX_GROUPS)) ? ROOM_W'(MAX_GROUPS) : req_room;

   always_comb begin
      w_valid_in = w_valid_ff;
      w_value_in = w_value_ff;
      w_room_in  = w_room_ff;
      if (req_accept) begin
         w_valid_in = 1'b1;
         w_value_in = $unsigned(req_value_in);
         w_room_in  = room_clamped;
      end else if (w_done) begin
         w_valid_in = 1'b0;
      end else if (fire && w_type_ff == REQ_ENCODE) begin
         // Move on to the next seven-bit group.
         w_value_in = enc.rest;
         w_room_in  = w_room_ff - 3'd1;
      end
   end

   // Unused fields of a result are zero.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         if (w_type_ff == REQ_ENCODE) begin
            rsp_kind_in  = KIND_BYTE;
            rsp_byte_in  = enc.out_byte;
            rsp_value_in = '0;
            rsp_last_in  = enc.last;
         end else if (dec_res.error) begin
            rsp_kind_in  = KIND_ERROR;
            rsp_byte_in  = '0;
            rsp_value_in = '0;
            rsp_last_in  = 1'b0;
         end else begin
            rsp_kind_in  = KIND_VALUE;
            rsp_byte_in  = '0;
            rsp_value_in = dec_res.value;
            rsp_last_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         w_valid_ff   <= w_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_value_ff   <= w_value_in;
      w_room_ff    <= w_room_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      if (req_accept) begin
         w_type_ff <= req_type;
         w_byte_ff <= req_in_byte;
         w_end_ff  <= req_buffer_end;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_decoded_value = $signed(rsp_value_ff);
   assign rsp_last          = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // The decoder never holds more than four pending groups.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      dec_count < MAX_GROUPS)
      else $error("decode group count out of range");

   // A finished decode clears the gathered groups.
   a_decode_clears: assert property (@(posedge clock) disable iff (reset)
      (dec_step && dec_res.valid) |=> (dec_count == '0))
      else $error("decode state not cleared after a result");

   // Only encoded bytes carry the last mark.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_kind == KIND_BYTE))
      else $error("last set on a non-byte result");

   // A byte that announces more bytes is only last when the room ran out.
   a_encode_room: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && w_type_ff == REQ_ENCODE && enc.rest != '0 && w_room_ff != 3'd1)
      |=> !rsp_last)
      else $error("encode run ended early");
`endif

endmodule

/* sim/varint_check_pkg.sv */
`timescale 1ns / 1ps

package varint_check_pkg;
   import vc32_pkg::*;

   // One output of the codec as it appears on the response port.
   typedef struct {
      logic [1:0]         kind;
      logic [7:0]         out_byte;
      logic [VALUE_W-1:0] value;
      logic               last;
   } codec_output_type;

   class varint_scoreboard;
      logic [VALUE_W-1:0] decode_accum;
      int unsigned        decode_groups;
      codec_output_type   outputs_due[$];
      int unsigned        mismatches;

      function new();
         decode_accum  = '0;
         decode_groups = 0;
         mismatches    = 0;
      endfunction

      // Works out the outputs that one accepted request causes and queues them.
      function void predict_request(logic rtype, logic [7:0] in_byte, logic buf_end,
                                    logic [VALUE_W-1:0] value, logic [ROOM_W-1:0] room);
         codec_output_type   item;
         codec_output_type   run[$];
         logic [VALUE_W-1:0] group_bits;
         logic [VALUE_W-1:0] cur;
         logic [VALUE_W-1:0] rest;
         int unsigned        shift;
         int unsigned        room_left;
         int unsigned        i;
         item = '{kind: KIND_BYTE, out_byte: 8'h00, value: '0, last: 1'b0};
         if (rtype == REQ_DECODE) begin
            shift = GROUP_W * decode_groups;
            group_bits = '0;
            group_bits[GROUP_W-1:0] = in_byte[GROUP_W-1:0];
            // Bits of the fifth group above bit 31 fall off here.
            if (shift < VALUE_W) decode_accum |= group_bits << shift;
            if ((in_byte & MORE_BIT) == 8'h00) begin
               item.kind  = KIND_VALUE;
               item.value = decode_accum;
               outputs_due.push_back(item);
               decode_accum  = '0;
               decode_groups = 0;
            end else if (decode_groups + 1 >= MAX_GROUPS || buf_end) begin
               item.kind = KIND_ERROR;
               outputs_due.push_back(item);
               decode_accum  = '0;
               decode_groups = 0;
            end else begin
               decode_groups++;
            end
         end else begin
            room_left = (room > MAX_GROUPS) ? MAX_GROUPS : room;
            for (i = 0; i < room_left; i++) begin
               cur  = value >> (GROUP_W * i);
               rest = value >> (GROUP_W * (i + 1));
               if (i != 0 && cur == '0) break;
               item.kind     = KIND_BYTE;
               item.out_byte = (cur[7:0] & GROUP_MASK) | ((rest != '0) ? MORE_BIT : 8'h00);
               item.last     = 1'b0;
               run.push_back(item);
            end
            if (run.size() > 0) run[run.size() - 1].last = 1'b1;
            foreach (run[k]) outputs_due.push_back(run[k]);
         end
      endfunction

      function void compare_output(logic [1:0] kind, logic [7:0] out_byte,
                                   logic [VALUE_W-1:0] value, logic last);
         codec_output_type want;
         if (outputs_due.size() == 0) begin
            $error("unexpected output: kind %0d byte %02h value %08h last %0b",
                   kind, out_byte, value, last);
            mismatches++;
            return;
         end
         want = outputs_due.pop_front();
         if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            mismatches++;
         end
         if (out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_byte);
            mismatches++;
         end
         if (value !== want.value) begin
            $error("decoded_value: expected %08h, got %08h", want.value, value);
            mismatches++;
         end
         if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            mismatches++;
         end
      endfunction

      function int unsigned outputs_pending();
         return outputs_due.size();
      endfunction
   endclass

endpackage

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import vc32_pkg::*;
   import varint_check_pkg::*;

   // A directed opening exercises the corner cases of both directions:
   // single-byte and five-byte values, the dropped bits of the fifth group, a
   // fifth byte that still continues, a buffer that runs out mid-value, an
   // encode request arriving in the middle of a decode, and encode requests
   // with every room setting from zero to seven. A random phase then sends
   // mostly well-formed byte runs with random content, mixed with encode
   // requests, broken runs and stray bytes. Every accepted request is fed to
   // the scoreboard, which predicts the outputs it causes; every accepted
   // output is checked against the oldest prediction.

   localparam int unsigned RANDOM_ITEMS     = 315;
   localparam int unsigned CALM_TAIL_ITEMS  = 50;
   localparam int unsigned MODE_SPAN        = 40;
   localparam int unsigned LONG_HOLD_CYCLES = 400;
   localparam int unsigned WATCHDOG_LIMIT   = 4000;
   // After the last predicted output, the drain keeps watching to catch strays.
   localparam int unsigned DRAIN_CYCLES     = 20;

   // Idle pressure: 0 means none, 1 light, 2 heavy.
   localparam int unsigned IDLE_NONE  = 0;
   localparam int unsigned IDLE_LIGHT = 1;
   localparam int unsigned IDLE_HEAVY = 2;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_type = REQ_DECODE;
   logic [7:0]                req_in_byte = 8'h00;
   logic                      req_buffer_end = 1'b0;
   logic signed [VALUE_W-1:0] req_value_in = '0;
   logic [ROOM_W-1:0]         req_room = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [1:0]                rsp_kind;
   logic [7:0]                rsp_out_byte;
   logic signed [VALUE_W-1:0] rsp_decoded_value;
   logic                      rsp_last;

   varint_scoreboard codec_check = new();

   int unsigned items_sent   = 0;
   int unsigned idle_mode    = IDLE_LIGHT;
   int unsigned quiet_cycles = 0;
   bit          long_hold_due = 1'b0;

   varint32_codec u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_in_byte       (req_in_byte),
      .req_buffer_end    (req_buffer_end),
      .req_value_in      (req_value_in),
      .req_room          (req_room),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_decoded_value (rsp_decoded_value),
      .rsp_last          (rsp_last)
   );

   always #1 clock = ~clock;

   // Decides whether a side takes a gap now, given the current idle pressure.
   function automatic bit gap_now();
      case (idle_mode)
         IDLE_LIGHT: return $urandom_range(0, 7) == 0;
         IDLE_HEAVY: return $urandom_range(0, 2) == 0;
         default:    return 1'b0;
      endcase
   endfunction

   // Values spread over all magnitudes, so short and long encodings both occur.
   function automatic logic [VALUE_W-1:0] random_value();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return $urandom >> $urandom_range(0, 31);
   endfunction

   // Offers one request and returns at the edge that accepts it. The payload is
   // held steady until then, and a random gap may come before the offer.
   task automatic send_request(input logic rtype, input logic [7:0] in_byte,
                               input logic buf_end, input logic [VALUE_W-1:0] value,
                               input logic [ROOM_W-1:0] room);
      if (gap_now()) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= rtype;
      req_in_byte    <= in_byte;
      req_buffer_end <= buf_end;
      req_value_in   <= value;
      req_room       <= room;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // The fields a request does not use still carry random junk.
   task automatic send_decode(input logic [7:0] in_byte, input logic buf_end);
      send_request(REQ_DECODE, in_byte, buf_end, $urandom, 3'($urandom_range(0, 7)));
   endtask

   task automatic send_encode(input logic [VALUE_W-1:0] value, input logic [ROOM_W-1:0] room);
      send_request(REQ_ENCODE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   value, room);
   endtask

   // Sends a value as a well-formed run of n_bytes bytes. Runs longer than the
   // value needs carry zero groups, which the decoder must still accept. An
   // encode request may slip in between bytes without disturbing the decode.
   task automatic send_varint_run(input logic [VALUE_W-1:0] value, input int unsigned n_bytes);
      logic [7:0]  data_byte;
      logic [VALUE_W-1:0] group;
      int unsigned i;
      for (i = 0; i < n_bytes; i++) begin
         group = value >> (GROUP_W * i);
         data_byte = (group[7:0] & GROUP_MASK) | ((i + 1 < n_bytes) ? MORE_BIT : 8'h00);
         if (i > 0 && $urandom_range(0, 7) == 0) begin
            send_encode(random_value(), 3'($urandom_range(0, 7)));
         end
         // The buffer may end on a completing byte; that is not an error.
         send_decode(data_byte, (i + 1 == n_bytes) ? 1'($urandom_range(0, 1)) : 1'b0);
      end
   endtask

   // Either five bytes that all continue, or a run that continues into the
   // end of the buffer. Both must end in a decode error.
   task automatic send_broken_run();
      int unsigned n_bytes;
      int unsigned i;
      if ($urandom_range(0, 1) == 0) begin
         for (i = 0; i < MAX_GROUPS; i++) begin
            send_decode(MORE_BIT | 8'($urandom_range(0, 127)), 1'b0);
         end
      end else begin
         n_bytes = $urandom_range(1, 4);
         for (i = 0; i < n_bytes; i++) begin
            send_decode(MORE_BIT | 8'($urandom_range(0, 127)), i + 1 == n_bytes);
         end
      end
   endtask

   function automatic int unsigned natural_length(input logic [VALUE_W-1:0] value);
      int unsigned n;
      n = 1;
      while (n < MAX_GROUPS && (value >> (GROUP_W * n)) != '0) n++;
      return n;
   endfunction

   // Scoreboard feed and watchdog. Signals are read right after the edge, so
   // they hold the values that the edge itself saw.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            codec_check.predict_request(req_type, req_in_byte, req_buffer_end,
                                        req_value_in, req_room);
         end
         if (rsp_valid && rsp_ready) begin
            codec_check.compare_output(rsp_kind, rsp_out_byte, rsp_decoded_value, rsp_last);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("varint32_codec verification failed");
            $finish;
         end
      end
   end

   // Response side. Besides short random stalls, it holds off once for a long
   // stretch so that the codec backs up and stops taking requests.
   initial begin
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (gap_now()) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Request side: reset, directed cases, random traffic, then the drain.
   initial begin
      int unsigned stimulus_target;
      int unsigned next_mode_change;
      int unsigned hold_point;
      bit          hold_done;
      logic [VALUE_W-1:0] value;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Single-byte values at both ends, one of them at the end of the buffer.
      send_decode(8'h00, 1'b0);
      send_decode(8'h7F, 1'b1);
      // A two-byte value with every data bit set.
      send_decode(8'hFF, 1'b0);
      send_decode(8'h7F, 1'b0);
      // The largest five-byte value; then a fifth group whose high bits drop.
      send_varint_run(32'hFFFF_FFFF, 5);
      send_decode(8'hFF, 1'b0);
      send_decode(8'hFF, 1'b0);
      send_decode(8'hFF, 1'b0);
      send_decode(8'hFF, 1'b0);
      send_decode(8'h7F, 1'b0);
      // A fifth byte that still continues.
      send_decode(8'h80, 1'b0);
      send_decode(8'h80, 1'b0);
      send_decode(8'h80, 1'b0);
      send_decode(8'h80, 1'b0);
      send_decode(8'h80, 1'b0);
      // The buffer ends while a value is open.
      send_decode(8'h81, 1'b1);
      // An encode request in the middle of a decode leaves it intact.
      send_decode(8'h85, 1'b0);
      send_encode(32'd300, 3'd7);
      send_decode(8'h01, 1'b0);
      // Encode: room zero, room cutting a run short, room six, and
      // the extremes of the value.
      send_encode(32'd300, 3'd0);
      send_encode(32'd300, 3'd1);
      send_encode(32'd0, 3'd1);
      send_encode(32'hFFFF_FFFF, 3'd6);
      send_encode(32'h8000_0000, 3'd3);
      send_encode(32'h7FFF_FFFF, 3'd5);
      send_encode(32'd128, 3'd2);
      send_encode(32'd127, 3'd4);

      stimulus_target  = items_sent + RANDOM_ITEMS;
      next_mode_change = items_sent + MODE_SPAN;
      hold_point       = items_sent + 100;
      hold_done        = 1'b0;
      while (items_sent < stimulus_target) begin
         if (items_sent >= next_mode_change) begin
            idle_mode = $urandom_range(IDLE_NONE, IDLE_HEAVY);
            next_mode_change = items_sent + MODE_SPAN;
         end
         if (items_sent + CALM_TAIL_ITEMS >= stimulus_target) idle_mode = IDLE_NONE;
         if (!hold_done && items_sent >= hold_point) begin
            long_hold_due = 1'b1;
            hold_done = 1'b1;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               value = random_value();
               // Mostly the shortest encoding, sometimes padded with zero groups.
               if ($urandom_range(0, 3) == 0) begin
                  send_varint_run(value, $urandom_range(natural_length(value), MAX_GROUPS));
               end else begin
                  send_varint_run(value, natural_length(value));
               end
            end
            5, 6, 7: send_encode(random_value(), 3'($urandom_range(0, 7)));
            8:       send_broken_run();
            default: send_decode(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         endcase
      end
      req_valid <= 1'b0;

      while (codec_check.outputs_pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (codec_check.mismatches == 0 && codec_check.outputs_pending() == 0) begin
         $display("varint32_codec verification clean");
      end else begin
         $display("varint32_codec verification failed");
      end
      $finish;
   end

endmodule
